// ===== design/sca_pkg.sv =====
package sca_pkg;

  // Default ring buffer depth, a power of two
  localparam int unsigned BUFFER_DEPTH_DEF = 128;

  localparam int unsigned SCAN_W = 8;
  localparam int unsigned CHAR_W = 7;

  // Transaction kind
  typedef enum logic {
    FUNC_SCAN = 1'b0,
    FUNC_READ = 1'b1
  } func_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_STORED    = 3'd0,
    ST_IGNORED   = 3'd1,
    ST_DROPPED   = 3'd2,
    ST_DELIVERED = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef struct packed {
    func_t             func;
    logic [SCAN_W-1:0] scan_byte;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [CHAR_W-1:0] char_code;
  } rsp_t;

  // Control characters in the key map
  localparam logic [CHAR_W-1:0] ASCII_ESC = 7'h1B;
  localparam logic [CHAR_W-1:0] ASCII_BS  = 7'h08;
  localparam logic [CHAR_W-1:0] ASCII_TAB = 7'h09;
  localparam logic [CHAR_W-1:0] ASCII_LF  = 7'h0A;

  // Set-1 make code to unshifted ASCII; zero means unmapped
  function automatic logic [CHAR_W-1:0] key_map(input logic [CHAR_W-1:0] code);
    logic [CHAR_W-1:0] ch;
    unique case (code)
      7'd1:    ch = ASCII_ESC;
      7'd2:    ch = 7'h31;
      7'd3:    ch = 7'h32;
      7'd4:    ch = 7'h33;
      7'd5:    ch = 7'h34;
      7'd6:    ch = 7'h35;
      7'd7:    ch = 7'h36;
      7'd8:    ch = 7'h37;
      7'd9:    ch = 7'h38;
      7'd10:   ch = 7'h39;
      7'd11:   ch = 7'h30;
      7'd12:   ch = 7'h2D;
      7'd13:   ch = 7'h3D;
      7'd14:   ch = ASCII_BS;
      7'd15:   ch = ASCII_TAB;
      7'd16:   ch = 7'h71;
      7'd17:   ch = 7'h77;
      7'd18:   ch = 7'h65;
      7'd19:   ch = 7'h72;
      7'd20:   ch = 7'h74;
      7'd21:   ch = 7'h79;
      7'd22:   ch = 7'h75;
      7'd23:   ch = 7'h69;
      7'd24:   ch = 7'h6F;
      7'd25:   ch = 7'h70;
      7'd26:   ch = 7'h5B;
      7'd27:   ch = 7'h5D;
      7'd28:   ch = ASCII_LF;
      7'd30:   ch = 7'h61;
      7'd31:   ch = 7'h73;
      7'd32:   ch = 7'h64;
      7'd33:   ch = 7'h66;
      7'd34:   ch = 7'h67;
      7'd35:   ch = 7'h68;
      7'd36:   ch = 7'h6A;
      7'd37:   ch = 7'h6B;
      7'd38:   ch = 7'h6C;
      7'd39:   ch = 7'h3B;
      7'd40:   ch = 7'h27;
      7'd41:   ch = 7'h60;
      7'd43:   ch = 7'h5C;
      7'd44:   ch = 7'h7A;
      7'd45:   ch = 7'h78;
      7'd46:   ch = 7'h63;
      7'd47:   ch = 7'h76;
      7'd48:   ch = 7'h62;
      7'd49:   ch = 7'h6E;
      7'd50:   ch = 7'h6D;
      7'd51:   ch = 7'h2C;
      7'd52:   ch = 7'h2E;
      7'd53:   ch = 7'h2F;
      7'd55:   ch = 7'h2A;
      7'd57:   ch = 7'h20;
      7'd74:   ch = 7'h2D;
      7'd78:   ch = 7'h2B;
      default: ch = '0;
    endcase
    return ch;
  endfunction

endpackage

// ===== design/scancode_to_ascii_fifo.sv =====
// Scancode to ASCII character FIFO. Each request transaction is either a
// set-1 scancode (func = FUNC_SCAN) or a read (func = FUNC_READ), and each
// produces exactly one response transaction with a status and, on a
// successful read, the oldest buffered character. The block takes one
// request per cycle unless a held response stalls it: pointer compare, key
// map lookup and the store write all happen in the accept cycle, and the
// store's registered read port returns the character in the next cycle,
// together with the response, which sits in a single output register;
// req_ready stays high whenever that register is empty or being drained in
// the same cycle. The buffer holds BUFFER_DEPTH-1 characters. The store
// needs no clearing pass after reset, as only written entries are ever read.
module scancode_to_ascii_fifo
  import sca_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int unsigned PTR_W = (BUFFER_DEPTH > 2) ? $clog2(BUFFER_DEPTH) : 1;

  logic [CHAR_W-1:0] char_store [BUFFER_DEPTH];

  logic [PTR_W-1:0]  wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0]  rd_ptr, rd_ptr_next;
  logic [CHAR_W-1:0] rd_data;
  status_t           rsp_status, status_next;

  logic              req_fire;
  logic              store_we;
  logic              store_re;
  logic [CHAR_W-1:0] mapped;
  logic [PTR_W-1:0]  wr_ptr_inc;
  logic              buf_empty;
  logic              buf_full;

  // Output register frees up when empty or drained this cycle
  assign req_ready = !rsp_valid || rsp_ready;
  assign req_fire  = req_valid && req_ready;

  assign mapped     = key_map(req.scan_byte[CHAR_W-1:0]);
  assign wr_ptr_inc = wr_ptr + 1'b1;
  assign buf_empty  = (wr_ptr == rd_ptr);
  assign buf_full   = (wr_ptr_inc == rd_ptr);

  // Classify the transaction and decide the pointer moves
  always_comb begin
    status_next = ST_IGNORED;
    store_we    = 1'b0;
    store_re    = 1'b0;
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    if (req.func == FUNC_READ) begin
      if (buf_empty) begin
        status_next = ST_EMPTY;
      end else begin
        status_next = ST_DELIVERED;
        store_re    = req_fire;
        if (req_fire) rd_ptr_next = rd_ptr + 1'b1;
      end
    end else if (req.scan_byte[SCAN_W-1] || (mapped == '0)) begin
      status_next = ST_IGNORED;
    end else if (buf_full) begin
      status_next = ST_DROPPED;
    end else begin
      status_next = ST_STORED;
      store_we    = req_fire;
      if (req_fire) wr_ptr_next = wr_ptr_inc;
    end
  end

  // Character store: one write port, one registered read port.
  // A read never targets the slot written in the same cycle.
  always_ff @(posedge clk) begin
    if (store_we) char_store[wr_ptr] <= mapped;
    if (store_re) rd_data <= char_store[rd_ptr];
  end

  // Pointers and response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      if (req_fire) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

  // Response status; rd_data only moves on a delivering read
  always_ff @(posedge clk) begin
    if (req_fire) rsp_status <= status_next;
  end

  assign rsp.status    = rsp_status;
  assign rsp.char_code = (rsp_status == ST_DELIVERED) ? rd_data : '0;

  // A read on an empty buffer reports empty
  a_empty_read: assert property (@(posedge clk) disable iff (rst)
    (req_fire && req.func == FUNC_READ && wr_ptr == rd_ptr)
      |=> (rsp_valid && rsp.status == ST_EMPTY))
    else $error("empty read did not report empty");

  // A stored character advances the write pointer by one
  a_store_adv: assert property (@(posedge clk) disable iff (rst)
    (req_fire && status_next == ST_STORED)
      |=> (wr_ptr == PTR_W'($past(wr_ptr) + 1'b1)) && $stable(rd_ptr))
    else $error("write pointer did not advance on store");

  // A delivered character advances the read pointer by one
  a_read_adv: assert property (@(posedge clk) disable iff (rst)
    (req_fire && status_next == ST_DELIVERED)
      |=> (rd_ptr == PTR_W'($past(rd_ptr) + 1'b1)) && $stable(wr_ptr))
    else $error("read pointer did not advance on delivery");

endmodule
